// File: rtl/dnle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnle_pkg;

   // Byte width of characters and wire-format output
   localparam int unsigned DATA_W = 8;

   // Label separator character
   localparam logic [DATA_W-1:0] SEPARATOR = 8'h2e;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;       // input word taken this cycle
      logic load_len;     // load length byte into output register
      logic load_char;    // load buffered character, advance read index
      logic load_term;    // load zero terminator
      logic clear_label;  // label fully emitted, reset count and flag
      logic run_last;     // run_last bit for the byte being loaded
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic in_sep;       // incoming character is the separator
      logic count_zero;   // open label is empty
      logic last_char;    // read index points at the final buffered character
      logic name_last;    // captured name_last of the item in progress
      logic out_free;     // output register can take a word this cycle
   } status_type;

endpackage

`default_nettype wire

// File: rtl/dnle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dnle_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_name_last,
   output logic                     req_ready,
   input  wire dnle_pkg::status_type status,
   output dnle_pkg::cmd_type        cmd
);
   import dnle_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_CHAR = 2'd2;
   localparam logic [1:0] ST_TERM = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && (status.in_sep || req_name_last)) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (status.out_free) begin
               cmd.load_len = 1'b1;
               cmd.run_last = !status.name_last && status.count_zero;
               if (!status.count_zero) begin
                  state_in = ST_CHAR;
               end else begin
                  cmd.clear_label = 1'b1;
                  state_in        = status.name_last ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_CHAR: begin
            if (status.out_free) begin
               cmd.load_char = 1'b1;
               cmd.run_last  = !status.name_last && status.last_char;
               if (status.last_char) begin
                  cmd.clear_label = 1'b1;
                  state_in        = status.name_last ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.load_term = 1'b1;
               cmd.run_last  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Character emission only happens for a non-empty label
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR) |-> !status.count_zero)
      else $error("char state with empty label");

   // At most one output load per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_len, cmd.load_char, cmd.load_term}))
      else $error("multiple output loads");

endmodule

`default_nettype wire

// File: rtl/dnle_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dnle_datapath #(
   parameter int unsigned MAX_LABEL = 62
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [dnle_pkg::DATA_W-1:0] req_ch,
   input  wire logic                       req_name_last,
   input  wire dnle_pkg::cmd_type          cmd,
   output dnle_pkg::status_type            status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [dnle_pkg::DATA_W-1:0]     rsp_out_byte,
   output logic                            rsp_run_last,
   output logic                            rsp_name_end,
   output logic                            rsp_label_overflow
);
   import dnle_pkg::*;

   localparam int unsigned CntW  = $clog2(MAX_LABEL + 1);
   localparam int unsigned AddrW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

   // Label character store, single write port and registered read
   logic [DATA_W-1:0] store [MAX_LABEL];
   logic [DATA_W-1:0] rd_data_ff;
   logic [AddrW-1:0]  rd_addr;

   logic [CntW-1:0]   count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              last_ff, last_in;
   logic [AddrW-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_byte_ff;
   logic              rsp_run_last_ff;
   logic              rsp_name_end_ff;
   logic              rsp_ovf_ff;

   logic              in_sep;
   logic              room;
   logic              last_char;
   logic              write_en;
   logic              out_free;
   logic              load_any;

   assign in_sep    = (req_ch == SEPARATOR);
   assign room      = (count_ff < CntW'(MAX_LABEL));
   assign write_en  = cmd.accept && !in_sep && room;
   assign last_char = ((CntW'(idx_ff) + CntW'(1)) == count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_any  = cmd.load_len || cmd.load_char || cmd.load_term;

   // Read one ahead while advancing so characters stream at one per cycle while the output is free
   assign rd_addr = (cmd.load_char && !last_char) ? (idx_ff + AddrW'(1)) : idx_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         store[count_ff[AddrW-1:0]] <= req_ch;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store[rd_addr];
   end

   // Label count, overflow flag, read index, captured name_last
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (cmd.accept) begin
         last_in = req_name_last;
         idx_in  = '0;
         if (!in_sep) begin
            if (room) begin
               count_in = count_ff + CntW'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end else if (cmd.clear_label) begin
         count_in = '0;
         ovf_in   = 1'b0;
         idx_in   = '0;
      end else if (cmd.load_char) begin
         idx_in = idx_ff + AddrW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         last_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
         idx_ff   <= idx_in;
      end
   end

   // Output register
   assign rsp_valid_in = load_any || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_any) begin
         rsp_run_last_ff <= cmd.run_last;
         rsp_name_end_ff <= cmd.load_term;
         rsp_ovf_ff      <= cmd.load_len && ovf_ff;
         if (cmd.load_len) begin
            rsp_byte_ff <= DATA_W'(count_ff);
         end else if (cmd.load_char) begin
            rsp_byte_ff <= rd_data_ff;
         end else begin
            rsp_byte_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_run_last       = rsp_run_last_ff;
   assign rsp_name_end       = rsp_name_end_ff;
   assign rsp_label_overflow = rsp_ovf_ff;

   assign status.in_sep     = in_sep;
   assign status.count_zero = (count_ff == '0);
   assign status.last_char  = last_char;
   assign status.name_last  = last_ff;
   assign status.out_free   = out_free;

   // Label count never passes the limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_LABEL))
      else $error("label count above limit");

   // Truncation only flagged once the label is full
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CntW'(MAX_LABEL)))
      else $error("overflow flag with label not full");

   // Terminator load lands as a valid name_end word
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_term |=> (rsp_valid_ff && rsp_name_end_ff && rsp_byte_ff == '0))
      else $error("terminator not presented");

endmodule

`default_nettype wire

// File: rtl/dns_name_label_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

// DNS name label encoder: takes a dotted name one character per word and
// emits the wire-format byte stream (length byte, label characters, zero
// terminator). An ordinary character is accepted and produces nothing, and
// the next word can follow it straight away. A separator or the word marked
// name_last is accepted, then the block emits 1 length byte plus n buffered
// characters (plus 1 terminator byte for name_last) at one byte per cycle
// while rsp_ready is high; no new word is accepted until the label store has
// been drained. The rate is set by the output register, which moves one byte
// per cycle while rsp_ready is high, and by the controller holding off input
// while a label drains. Labels longer than MAX_LABEL are truncated and the
// length byte carries label_overflow. The store needs no clearing after reset.
module dns_name_label_encoder #(
   parameter int unsigned MAX_LABEL = 62
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [dnle_pkg::DATA_W-1:0] req_ch,
   input  wire logic                       req_name_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [dnle_pkg::DATA_W-1:0]     rsp_out_byte,
   output logic                            rsp_run_last,
   output logic                            rsp_name_end,
   output logic                            rsp_label_overflow
);
   import dnle_pkg::*;

   cmd_type    cmd;
   status_type status;

   dnle_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_name_last (req_name_last),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   dnle_datapath #(
      .MAX_LABEL (MAX_LABEL)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_ch             (req_ch),
      .req_name_last      (req_name_last),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_name_end       (rsp_name_end),
      .rsp_label_overflow (rsp_label_overflow)
   );

endmodule

`default_nettype wire

// File: test/dns_name_label_encoder_test.sv
`timescale 1ns / 1ps

module dns_name_label_encoder_test;
   import dnle_pkg::*;

   localparam int MAX_LABEL = 62;

   // one wire-format byte as seen on the rsp_ port
   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              run_last;
      logic              name_end;
      logic              label_overflow;
   } wire_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_ch = '0;
   logic              req_name_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   logic [DATA_W-1:0] rsp_out_byte;
   logic              rsp_run_last;
   logic              rsp_name_end;
   logic              rsp_label_overflow;

   // predictor state: the open label
   logic [DATA_W-1:0] open_label [0:MAX_LABEL-1];
   int                open_len = 0;
   logic              open_trunc = 1'b0;
   wire_byte_type     wire_bytes_due [$];

   // run bookkeeping
   int   error_count = 0;
   int   words_sent = 0;
   int   names_sent = 0;
   int   bytes_checked = 0;
   int   truncated_labels = 0;
   bit   no_idle = 1'b0;
   int   hold_request = 0;
   int   stall_left = 0;

   dns_name_label_encoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_ch             (req_ch),
      .req_name_last      (req_name_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_run_last       (rsp_run_last),
      .rsp_name_end       (rsp_name_end),
      .rsp_label_overflow (rsp_label_overflow)
   );

   always #5 clock = ~clock;

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // any byte except the separator
   function automatic logic [DATA_W-1:0] label_char();
      logic [DATA_W-1:0] c;
      do c = $urandom_range(0, 255); while (c == SEPARATOR);
      return c;
   endfunction

   // emit length byte and buffered characters of the open label
   task automatic close_label(input logic more_follow);
      int i;
      wire_bytes_due.push_back('{open_len[DATA_W-1:0], !more_follow && open_len == 0,
                                 1'b0, open_trunc});
      for (i = 0; i < open_len; i++)
         wire_bytes_due.push_back('{open_label[i], !more_follow && i == open_len - 1,
                                    1'b0, 1'b0});
      open_len = 0;
      open_trunc = 1'b0;
   endtask

   // expected wire bytes caused by one accepted word
   task automatic predict_wire_bytes(input logic [DATA_W-1:0] c, input logic last);
      if (c != SEPARATOR) begin
         if (open_len < MAX_LABEL) begin
            open_label[open_len] = c;
            open_len++;
         end else begin
            open_trunc = 1'b1;
         end
      end
      if (!last) begin
         if (c == SEPARATOR) close_label(1'b0);
      end else begin
         close_label(1'b1);
         wire_bytes_due.push_back('{'0, 1'b1, 1'b1, 1'b0});
      end
   endtask

   // offer one word, hold it until taken, then maybe idle
   task automatic send_word(input logic [DATA_W-1:0] c, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_ch <= c;
      req_name_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_wire_bytes(c, last);
      words_sent++;
      if (last) names_sent++;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // well-formed name: a few labels, sometimes empty, now and then longer
   task automatic send_random_name();
      int   nlabels, len, k, i, r;
      logic trailing, is_tail;
      nlabels = $urandom_range(1, 4);
      trailing = ($urandom_range(0, 3) == 0);
      for (k = 0; k < nlabels; k++) begin
         r = $urandom_range(0, 99);
         is_tail = (k == nlabels - 1);
         if (r < 8) len = 0;
         else if (r < 97) len = $urandom_range(1, 10);
         else len = $urandom_range(11, 20);
         if (is_tail && !trailing && len == 0) len = 1;
         for (i = 0; i < len; i++)
            send_word(label_char(), is_tail && !trailing && i == len - 1);
         if (!is_tail || trailing) send_word(SEPARATOR, is_tail);
      end
   endtask

   // noise: random bytes with frequent separators
   task automatic send_noise_name();
      int n, i;
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++)
         send_word(($urandom_range(0, 4) == 0) ? SEPARATOR : 8'($urandom_range(0, 255)),
                   i == n - 1);
   endtask

   // receiver: random stalls, plus a long hold when a test asks for one
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_len();
      end
   end

   // compare each taken result word with the oldest expectation
   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (wire_bytes_due.size() == 0) begin
            $error("unexpected result word: out_byte %h", rsp_out_byte);
            error_count++;
         end else begin
            want = wire_bytes_due.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_run_last);
               error_count++;
            end
            if (rsp_name_end !== want.name_end) begin
               $error("name_end: expected %b, got %b", want.name_end, rsp_name_end);
               error_count++;
            end
            if (rsp_label_overflow !== want.label_overflow) begin
               $error("label_overflow: expected %b, got %b", want.label_overflow,
                      rsp_label_overflow);
               error_count++;
            end
            if (want.label_overflow) truncated_labels++;
         end
      end
   end

   // short names hitting the special cases and byte extremes
   task automatic test_directed_names();
      no_idle = 1'b1;
      send_word(SEPARATOR, 1'b1);        // lone dot
      send_word(8'hff, 1'b1);            // single char name
      send_word(8'h00, 1'b1);            // zero byte as a character
      send_word(SEPARATOR, 1'b0);        // double dot
      send_word(SEPARATOR, 1'b1);
      no_idle = 1'b0;
      send_word(SEPARATOR, 1'b0);        // leading dot
      send_word(8'h80, 1'b1);
      send_word(8'h61, 1'b0);            // trailing dot
      send_word(8'h62, 1'b0);
      send_word(SEPARATOR, 1'b1);
      send_word(8'h7f, 1'b0);            // two labels
      send_word(8'h01, 1'b0);
      send_word(SEPARATOR, 1'b0);
      send_word(8'h2d, 1'b1);
   endtask

   // label past the length limit; flag must clear afterward
   task automatic test_long_labels();
      int i;
      no_idle = 1'b1;
      for (i = 0; i < MAX_LABEL + 1; i++) send_word(label_char(), 1'b0);
      send_word(SEPARATOR, 1'b0);
      no_idle = 1'b0;
      send_word(8'h7a, 1'b1);
   endtask

   // long receiver hold while the sender keeps offering short labels and separators
   task automatic test_output_stall();
      int i;
      hold_request = 200;
      @(posedge clock);
      @(posedge clock);
      no_idle = 1'b1;
      for (i = 0; i < 6; i++) begin
         send_word(label_char(), 1'b0);
         send_word(label_char(), 1'b0);
         send_word(SEPARATOR, i == 5);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_random_names();
      int start;
      start = words_sent;
      while (words_sent - start < 10) begin
         if ($urandom_range(0, 4) == 0) send_noise_name();
         else send_random_name();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_names();
      test_long_labels();
      test_output_stall();
      test_random_names();
      req_valid <= 1'b0;
      while (wire_bytes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Encoded %0d names from %0d input words: %0d wire bytes checked,",
               names_sent, words_sent, bytes_checked);
      $display("including %0d truncated labels and a long output stall.", truncated_labels);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
rtl/dnle_pkg.sv
rtl/dnle_ctrl.sv
rtl/dnle_datapath.sv
rtl/dns_name_label_encoder.sv
test/dns_name_label_encoder_test.sv
